// ===== sv/bba_pkg.sv =====
package bba_pkg;

   localparam int OUT_W       = 11;
   localparam int LG_W        = 4;
   localparam int CFG_W       = 4;
   localparam int ID_W        = 16;
   localparam int ORDER_RESET = 10;

   typedef enum logic [1:0] {
      KIND_ABSENT = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_USED   = 2'd2,
      KIND_SPLIT  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_RD,
      ST_CHK,
      ST_UP,
      ST_RIGHT,
      ST_LEFT,
      ST_CO_TEST,
      ST_CO_CHK,
      ST_CO_W2,
      ST_CO_W3,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      WR_NONE,
      WR_CLEAR,
      WR_SPLIT,
      WR_RIGHT,
      WR_USED,
      WR_FREE,
      WR_ABS_SELF,
      WR_ABS_SIB,
      WR_PARENT
   } wr_type;

   typedef enum logic [1:0] {
      NAV_NONE,
      NAV_DOWN,
      NAV_UP
   } nav_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_FAIL,
      RES_ALLOC,
      RES_FREE
   } res_type;

   typedef struct packed {
      logic    start;
      logic    rd_sib;
      wr_type  wr_op;
      nav_type nav;
      res_type res;
      logic    emit;
   } cmd_type;

   typedef struct packed {
      logic     cfg_wr;
      logic     clr_last;
      logic     op;
      logic     too_big;
      kind_type kind;
      logic     owner_match;
      logic     at_target;
      logic     below_order;
      logic     at_root;
      logic     idx_odd;
      logic     out_free;
   } status_type;

endpackage

// ===== sv/buddy_block_allocator.sv =====
// Buddy allocator: one transaction at a time, one response per request unless a csr write cuts it off.
// Each request walks the tree in preorder, reading each node and stepping back up as needed;
// allocate splits a free node level by level, free marks the owner's used node free and merges
// free buddy pairs upward. An allocate request larger than memory fails without a walk.
// The next request is accepted in the cycle in which rsp_tvalid for the previous one rises.
// Reset and every csr write clear all 2^(LEVELS+1) node words; reset order min(10, LEVELS).
module buddy_block_allocator
   import bba_pkg::*;
#(
   parameter int LEVELS     = 10,
   parameter int OWNER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,    // total_order
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,    // req_size[10:0], owner_id[26:11]
   input  logic             req_tuser,    // func
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,    // granted_size[10:0], free_units[21:11]
   output logic             rsp_tuser     // ok
);

   cmd_type    cmd;
   status_type status;

   bba_dpath #(
      .LEVELS    (LEVELS),
      .OWNER_BITS(OWNER_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .cmd       (cmd),
      .status    (status)
   );

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

endmodule

// ===== sv/bba_ram.sv =====
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/bba_dpath.sv =====
module bba_dpath
   import bba_pkg::*;
#(
   parameter int LEVELS     = 10,
   parameter int OWNER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic [31:0]      req_tdata,
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tuser,
   input  cmd_type          cmd,
   output status_type       status
);

   localparam int IDX_W      = LEVELS + 1;
   localparam int NODES      = 1 << IDX_W;
   localparam int ORD_W      = $clog2(LEVELS + 1);
   localparam int SIZE_W     = LEVELS + 1;
   localparam int WORD_W     = OWNER_BITS + 2;
   localparam int ORDER_INIT = (ORDER_RESET > LEVELS) ? LEVELS : ORDER_RESET;

   logic [ORD_W-1:0]      order_ff, order_in;
   logic [SIZE_W-1:0]     free_cnt_ff, free_cnt_in;
   logic [IDX_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [ORD_W-1:0]      depth_ff, depth_in;
   logic [LG_W-1:0]       lg_ff, lg_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic                  op_ff, op_in;
   logic [SIZE_W-1:0]     got_ff, got_in;
   logic                  res_ok_ff, res_ok_in;
   logic [SIZE_W-1:0]     res_size_ff, res_size_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [OUT_W-1:0]      rsp_size_ff, rsp_size_in;
   logic [OUT_W-1:0]      rsp_free_ff, rsp_free_in;

   logic [OUT_W-1:0]      want_size;
   logic [OUT_W-1:0]      size_m1;
   logic [LG_W-1:0]       req_lg;
   logic [ID_W-1:0]       req_owner;
   logic [4:0]            cfg_sat;
   logic [ORD_W-1:0]      cfg_order;
   logic [5:0]            tgt_wide;
   logic [ORD_W-1:0]      target;
   logic [SIZE_W-1:0]     alloc_size;
   logic [SIZE_W-1:0]     total_size;
   logic [IDX_W-1:0]      idx_down;
   logic [IDX_W-1:0]      idx_up;
   logic [IDX_W-1:0]      idx_sib;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   kind_type              mem_wkind;
   logic [WORD_W-1:0]     mem_wdata;
   logic [IDX_W-1:0]      mem_raddr;
   logic [WORD_W-1:0]     mem_rdata;

   assign want_size = req_tdata[10:0];
   assign req_owner = req_tdata[26:11];
   assign size_m1   = want_size - OUT_W'(1);

   always_comb begin
      req_lg = '0;
      for (int i = 0; i < OUT_W; i++) begin
         if (want_size > OUT_W'(1) && size_m1[i]) begin
            req_lg = LG_W'(i + 1);
         end
      end
   end

   assign cfg_sat    = (5'(csr_wdata) > 5'(LEVELS)) ? 5'(LEVELS) : 5'(csr_wdata);
   assign cfg_order  = cfg_sat[ORD_W-1:0];
   assign tgt_wide   = 6'(order_ff) - 6'(lg_ff);
   assign target     = tgt_wide[ORD_W-1:0];
   assign alloc_size = SIZE_W'(1) << lg_ff;
   assign total_size = SIZE_W'(1) << order_ff;
   assign idx_down   = {idx_ff[IDX_W-2:0], 1'b0};
   assign idx_up     = {1'b0, idx_ff[IDX_W-1:1]};
   assign idx_sib    = idx_ff ^ IDX_W'(1);

   always_comb begin
      order_in     = order_ff;
      free_cnt_in  = free_cnt_ff;
      clr_cnt_in   = clr_cnt_ff;
      idx_in       = idx_ff;
      depth_in     = depth_ff;
      lg_in        = lg_ff;
      owner_in     = owner_ff;
      op_in        = op_ff;
      got_in       = got_ff;
      res_ok_in    = res_ok_ff;
      res_size_in  = res_size_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_free_in  = rsp_free_ff;

      if (cmd.start) begin
         idx_in   = IDX_W'(1);
         depth_in = '0;
         lg_in    = req_lg;
         owner_in = OWNER_BITS'(req_owner);
         op_in    = req_tuser;
      end

      case (cmd.nav)
         NAV_DOWN: begin
            idx_in   = idx_down;
            depth_in = depth_ff + ORD_W'(1);
         end
         NAV_UP: begin
            if (idx_ff[0]) begin
               idx_in   = idx_up;
               depth_in = depth_ff - ORD_W'(1);
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase

      case (cmd.wr_op)
         WR_RIGHT: begin
            idx_in   = idx_down;
            depth_in = depth_ff + ORD_W'(1);
         end
         WR_PARENT: begin
            idx_in   = idx_up;
            depth_in = depth_ff - ORD_W'(1);
         end
         WR_FREE: got_in = SIZE_W'(1) << ORD_W'(order_ff - depth_ff);
         default: ;
      endcase

      case (cmd.res)
         RES_FAIL: begin
            res_ok_in   = 1'b0;
            res_size_in = '0;
         end
         RES_ALLOC: begin
            res_ok_in   = 1'b1;
            res_size_in = alloc_size;
            free_cnt_in = free_cnt_ff - alloc_size;
         end
         RES_FREE: begin
            res_ok_in   = 1'b1;
            res_size_in = got_ff;
            free_cnt_in = free_cnt_ff + got_ff;
         end
         default: ;
      endcase

      if (csr_we) begin
         order_in    = cfg_order;
         free_cnt_in = SIZE_W'(1) << cfg_order;
         clr_cnt_in  = '0;
      end else if (cmd.wr_op == WR_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + IDX_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_size_in  = OUT_W'(res_size_ff);
         rsp_free_in  = OUT_W'(free_cnt_ff);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= ORD_W'(ORDER_INIT);
         free_cnt_ff  <= SIZE_W'(1) << ORDER_INIT;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         order_ff     <= order_in;
         free_cnt_ff  <= free_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      depth_ff    <= depth_in;
      lg_ff       <= lg_in;
      owner_ff    <= owner_in;
      op_ff       <= op_in;
      got_ff      <= got_in;
      res_ok_ff   <= res_ok_in;
      res_size_ff <= res_size_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_size_ff <= rsp_size_in;
      rsp_free_ff <= rsp_free_in;
   end

   always_comb begin
      mem_we    = 1'b1;
      mem_waddr = idx_ff;
      mem_wkind = KIND_ABSENT;
      case (cmd.wr_op)
         WR_CLEAR: begin
            mem_waddr = clr_cnt_ff;
            mem_wkind = (clr_cnt_ff == IDX_W'(1)) ? KIND_FREE : KIND_ABSENT;
         end
         WR_SPLIT:    mem_wkind = KIND_SPLIT;
         WR_RIGHT: begin
            mem_waddr = {idx_ff[IDX_W-2:0], 1'b1};
            mem_wkind = KIND_FREE;
         end
         WR_USED:     mem_wkind = KIND_USED;
         WR_FREE:     mem_wkind = KIND_FREE;
         WR_ABS_SELF: mem_wkind = KIND_ABSENT;
         WR_ABS_SIB:  mem_waddr = idx_sib;
         WR_PARENT: begin
            mem_waddr = idx_up;
            mem_wkind = KIND_FREE;
         end
         default:     mem_we = 1'b0;
      endcase
   end

   assign mem_wdata = {owner_ff, mem_wkind};
   assign mem_raddr = cmd.rd_sib ? idx_sib : idx_ff;

   bba_ram #(
      .WIDTH(WORD_W),
      .DEPTH(NODES)
   ) u_node_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign status.cfg_wr      = csr_we;
   assign status.clr_last    = &clr_cnt_ff;
   assign status.op          = op_ff;
   assign status.too_big     = 6'(lg_ff) > 6'(order_ff);
   assign status.kind        = kind_type'(mem_rdata[1:0]);
   assign status.owner_match = mem_rdata[WORD_W-1:2] == owner_ff;
   assign status.at_target   = depth_ff == target;
   assign status.below_order = depth_ff < order_ff;
   assign status.at_root     = idx_ff == IDX_W'(1);
   assign status.idx_odd     = idx_ff[0];
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {2'b00, rsp_free_ff, rsp_size_ff};

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= total_size)
      else $error("free count above managed size");

   a_walk_idx: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op != WR_NONE && cmd.wr_op != WR_CLEAR) |-> idx_ff != '0)
      else $error("tree write at node zero");

   a_walk_depth: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op != WR_NONE && cmd.wr_op != WR_CLEAR) |-> depth_ff <= order_ff)
      else $error("walk below configured depth");

   a_res_alloc: assert property (@(posedge clock) disable iff (reset)
      cmd.res == RES_ALLOC |-> alloc_size <= free_cnt_ff)
      else $error("allocation exceeds free units");

endmodule

// ===== sv/bba_ctrl.sv =====
module bba_ctrl
   import bba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_op = WR_CLEAR;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            if (!status.op && status.too_big) begin
               cmd.res  = RES_FAIL;
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = ST_CHK;
         ST_CHK: begin
            if (!status.op) begin
               if (status.kind == KIND_FREE && status.at_target) begin
                  cmd.wr_op = WR_USED;
                  cmd.res   = RES_ALLOC;
                  state_in  = ST_DONE;
               end else if (status.kind == KIND_FREE) begin
                  state_in = ST_LEFT;
               end else if (status.kind == KIND_SPLIT && !status.at_target) begin
                  cmd.nav  = NAV_DOWN;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_UP;
               end
            end else begin
               if (status.kind == KIND_USED && status.owner_match) begin
                  cmd.wr_op = WR_FREE;
                  state_in  = ST_CO_TEST;
               end else if (status.kind == KIND_SPLIT && status.below_order) begin
                  cmd.nav  = NAV_DOWN;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_UP;
               end
            end
         end
         ST_UP: begin
            if (status.at_root) begin
               cmd.res  = RES_FAIL;
               state_in = ST_DONE;
            end else begin
               cmd.nav  = NAV_UP;
               state_in = status.idx_odd ? ST_UP : ST_RD;
            end
         end
         ST_LEFT: begin
            if (status.at_target) begin
               cmd.wr_op = WR_USED;
               cmd.res   = RES_ALLOC;
               state_in  = ST_DONE;
            end else begin
               cmd.wr_op = WR_SPLIT;
               state_in  = ST_RIGHT;
            end
         end
         ST_RIGHT: begin
            cmd.wr_op = WR_RIGHT;
            state_in  = ST_LEFT;
         end
         ST_CO_TEST: begin
            if (status.at_root) begin
               cmd.res  = RES_FREE;
               state_in = ST_DONE;
            end else begin
               cmd.rd_sib = 1'b1;
               state_in   = ST_CO_CHK;
            end
         end
         ST_CO_CHK: begin
            if (status.kind == KIND_FREE) begin
               cmd.wr_op = WR_ABS_SELF;
               state_in  = ST_CO_W2;
            end else begin
               cmd.res  = RES_FREE;
               state_in = ST_DONE;
            end
         end
         ST_CO_W2: begin
            cmd.wr_op = WR_ABS_SIB;
            state_in  = ST_CO_W3;
         end
         ST_CO_W3: begin
            cmd.wr_op = WR_PARENT;
            state_in  = ST_CO_TEST;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (status.cfg_wr) begin
         state_in = ST_CLEAR;
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == ST_START || state_ff == ST_CLEAR)
      else $error("accept did not start a walk");

   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit)
      else $error("two results for one transaction");

endmodule
